>>> rtl/pcc_pkg.sv
// Shared types and constants of the PI current controller.
`timescale 1ns / 1ps
`default_nettype none
package pcc_pkg;

	localparam int unsigned MAX_RUN_LENGTH_DEF = 1024;

	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 19;
	localparam int ERR_W    = 17;
	localparam int INTEG_W  = 18;
	localparam int ACC_W    = 19;
	localparam int PROD_P_W = GAIN_W + ERR_W;
	localparam int PROD_I_W = GAIN_W + INTEG_W;
	localparam int SUM_W    = PROD_I_W + 1;
	localparam int FRAC_W   = 16;
	localparam int DRIVE_W  = 17;
	localparam int IDX_W    = 10;
	localparam int CFG_W    = 19;
	localparam int DATA_W   = 80;

	localparam logic signed [18:0] KP_RST     = -19'sd13841;
	localparam logic signed [18:0] KI_RST     = -19'sd10066;
	localparam logic [15:0]        ILIM_RST   = 16'd1000;
	localparam logic [15:0]        PERIOD_RST = 16'd2400;
	localparam logic signed [15:0] TA_RST     = -16'sd300;
	localparam logic signed [15:0] TB_RST     = 16'sd300;
	localparam logic [9:0]         FLIP_RST   = 10'd100;
	localparam logic [10:0]        RUNLEN_RST = 11'd400;

	typedef enum logic [2:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_INT_GAIN       = 3'd1,
		REG_INTEGRAL_LIMIT = 3'd2,
		REG_BRIDGE_PERIOD  = 3'd3,
		REG_TARGET_A       = 3'd4,
		REG_TARGET_B       = 3'd5,
		REG_FLIP_PERIOD    = 3'd6,
		REG_RUN_LENGTH     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [18:0] prop_gain;
		logic signed [18:0] int_gain;
		logic [15:0]        integral_limit;
		logic [15:0]        bridge_period;
		logic signed [15:0] target_a;
		logic signed [15:0] target_b;
		logic [9:0]         flip_period;
		logic [10:0]        run_length;
	} cfg_t;

	typedef struct packed {
		logic signed [16:0] err;
		logic signed [17:0] acc;
		logic signed [15:0] target;
		logic [9:0]         idx;
		logic               active;
		logic               done;
	} step_beat_t;

endpackage
`default_nettype wire

>>> rtl/pcc_cfg.sv
// Configuration register file of the PI current controller.
`timescale 1ns / 1ps
`default_nettype none
module pcc_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [2:0]                    cfg_index,
	input  wire logic [pcc_pkg::CFG_W-1:0]     cfg_data,
	output pcc_pkg::cfg_t                      cfg
);

	pcc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= pcc_pkg::KP_RST;
			cfg_q.int_gain       <= pcc_pkg::KI_RST;
			cfg_q.integral_limit <= pcc_pkg::ILIM_RST;
			cfg_q.bridge_period  <= pcc_pkg::PERIOD_RST;
			cfg_q.target_a       <= pcc_pkg::TA_RST;
			cfg_q.target_b       <= pcc_pkg::TB_RST;
			cfg_q.flip_period    <= pcc_pkg::FLIP_RST;
			cfg_q.run_length     <= pcc_pkg::RUNLEN_RST;
		end else if (cfg_valid) begin
			unique case (pcc_pkg::cfg_idx_t'(cfg_index))
				pcc_pkg::REG_PROP_GAIN:      cfg_q.prop_gain      <= signed'(cfg_data);
				pcc_pkg::REG_INT_GAIN:       cfg_q.int_gain       <= signed'(cfg_data);
				pcc_pkg::REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data[15:0];
				pcc_pkg::REG_BRIDGE_PERIOD:  cfg_q.bridge_period  <= cfg_data[15:0];
				pcc_pkg::REG_TARGET_A:       cfg_q.target_a       <= signed'(cfg_data[15:0]);
				pcc_pkg::REG_TARGET_B:       cfg_q.target_b       <= signed'(cfg_data[15:0]);
				pcc_pkg::REG_FLIP_PERIOD:    cfg_q.flip_period    <= cfg_data[9:0];
				pcc_pkg::REG_RUN_LENGTH:     cfg_q.run_length     <= cfg_data[10:0];
				default:                     cfg_q                <= cfg_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/pcc_step.sv
// Input register, run sequencer and clamped integrator of the PI current controller.
`timescale 1ns / 1ps
`default_nettype none
module pcc_step #(
	parameter int unsigned MAX_RUN_LENGTH = pcc_pkg::MAX_RUN_LENGTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  pcc_pkg::cfg_t                         cfg,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic signed [pcc_pkg::SAMPLE_W-1:0] in_sample,
	input  wire logic                             in_start,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output pcc_pkg::step_beat_t                   out_beat
);

	localparam int CW = $clog2(MAX_RUN_LENGTH + 1);
	localparam int XW = 18;

	logic                                  v_s1;
	logic signed [pcc_pkg::SAMPLE_W-1:0]   sample_s1;
	logic                                  start_s1;
	logic                                  v_s2;
	pcc_pkg::step_beat_t                   beat_s2;

	logic                                  running_q;
	logic [CW-1:0]                         step_q;
	logic signed [15:0]                    target_q;
	logic signed [pcc_pkg::INTEG_W-1:0]    integ_q;

	logic                                  rdy_s2;
	logic                                  adv_s1;
	logic                                  arm;
	logic                                  run;
	logic signed [15:0]                    tgt;
	logic signed [pcc_pkg::INTEG_W-1:0]    integ;
	logic [CW-1:0]                         cnt_base;
	logic signed [pcc_pkg::ERR_W-1:0]      err;
	logic signed [pcc_pkg::ACC_W-1:0]      acc_sum;
	logic signed [pcc_pkg::ACC_W-1:0]      lim_p;
	logic signed [pcc_pkg::ACC_W-1:0]      lim_n;
	logic signed [pcc_pkg::ACC_W-1:0]      acc;
	logic [XW-1:0]                         cnt;
	logic [XW-1:0]                         len_raw;
	logic [XW-1:0]                         len_max;
	logic [XW-1:0]                         len_sat;
	logic [XW-1:0]                         len;
	logic [XW-1:0]                         fp1;
	logic [XW-1:0]                         fp2;
	logic [XW-1:0]                         fp3;
	logic                                  done;
	logic signed [15:0]                    tgt_next;
	pcc_pkg::step_beat_t                   beat_d;

	assign rdy_s2    = !v_s2 || out_ready;
	assign adv_s1    = v_s1 && rdy_s2;
	assign in_ready  = !v_s1 || rdy_s2;
	assign out_valid = v_s2;
	assign out_beat  = beat_s2;

	always_comb begin
		arm      = !running_q && start_s1;
		run      = running_q || start_s1;
		tgt      = arm ? cfg.target_a : target_q;
		integ    = arm ? '0 : integ_q;
		cnt_base = arm ? '0 : step_q;

		err     = pcc_pkg::ERR_W'(tgt) - pcc_pkg::ERR_W'(sample_s1);
		acc_sum = pcc_pkg::ACC_W'(integ) + pcc_pkg::ACC_W'(err);
		lim_p   = signed'({3'b000, cfg.integral_limit});
		lim_n   = -lim_p;
		priority if (acc_sum > lim_p) acc = lim_p;
		else if (acc_sum < lim_n)     acc = lim_n;
		else                          acc = acc_sum;

		cnt     = XW'(cnt_base) + XW'(1);
		len_raw = XW'(cfg.run_length);
		len_max = XW'(MAX_RUN_LENGTH);
		len_sat = (len_raw > len_max) ? len_max : len_raw;
		len     = (len_sat == '0) ? XW'(1) : len_sat;
		done    = cnt >= len;

		fp1 = XW'(cfg.flip_period);
		fp2 = fp1 << 1;
		fp3 = fp1 + fp2;
		tgt_next = tgt;
		if (fp1 != '0) begin
			priority if (cnt == fp1) tgt_next = cfg.target_b;
			else if (cnt == fp2)     tgt_next = cfg.target_a;
			else if (cnt == fp3)     tgt_next = cfg.target_b;
			else                     tgt_next = tgt;
		end

		beat_d.err    = run ? err : '0;
		beat_d.acc    = run ? pcc_pkg::INTEG_W'(acc) : '0;
		beat_d.target = run ? tgt : target_q;
		beat_d.idx    = run ? pcc_pkg::IDX_W'(cnt_base) : '0;
		beat_d.active = run;
		beat_d.done   = run && done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			running_q <= 1'b0;
			step_q    <= '0;
			target_q  <= pcc_pkg::TA_RST;
			integ_q   <= '0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s1 && run) begin
				if (done) begin
					running_q <= 1'b0;
					step_q    <= '0;
					integ_q   <= '0;
					target_q  <= cfg.target_a;
				end else begin
					running_q <= 1'b1;
					step_q    <= CW'(cnt);
					integ_q   <= pcc_pkg::INTEG_W'(acc);
					target_q  <= tgt_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_s1 <= in_sample;
			start_s1  <= in_start;
		end
		if (adv_s1) begin
			beat_s2 <= beat_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/pcc_drive.sv
// Gain multipliers, drive saturation and bridge compare mapping of the PI current controller.
`timescale 1ns / 1ps
`default_nettype none
module pcc_drive (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  pcc_pkg::cfg_t                        cfg,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  pcc_pkg::step_beat_t                  in_beat,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [15:0]                          compare_fwd,
	output logic [15:0]                          compare_rev,
	output logic signed [pcc_pkg::DRIVE_W-1:0]   drive,
	output logic signed [15:0]                   target_current,
	output logic [pcc_pkg::IDX_W-1:0]            step_index,
	output logic                                 active,
	output logic                                 run_done
);

	localparam int QW = pcc_pkg::SUM_W - pcc_pkg::FRAC_W;

	logic                                   v_s3;
	logic signed [pcc_pkg::PROD_P_W-1:0]    prod_p_s3;
	logic signed [pcc_pkg::PROD_I_W-1:0]    prod_i_s3;
	logic signed [15:0]                     target_s3;
	logic [pcc_pkg::IDX_W-1:0]              idx_s3;
	logic                                   active_s3;
	logic                                   done_s3;
	logic                                   v_q;

	logic                                   rdy_o;
	logic                                   adv_s3;
	logic signed [pcc_pkg::PROD_P_W-1:0]    prod_p;
	logic signed [pcc_pkg::PROD_I_W-1:0]    prod_i;
	logic signed [pcc_pkg::SUM_W-1:0]       sum;
	logic                                   neg;
	logic [pcc_pkg::SUM_W-1:0]              mag;
	logic [QW-1:0]                          quo;
	logic [15:0]                            dmag;
	logic                                   pos;
	logic [15:0]                            period_less;
	logic [15:0]                            fwd_d;
	logic [15:0]                            rev_d;
	logic signed [pcc_pkg::DRIVE_W-1:0]     drive_d;

	assign rdy_o     = !v_q || out_ready;
	assign adv_s3    = v_s3 && rdy_o;
	assign in_ready  = !v_s3 || rdy_o;
	assign out_valid = v_q;

	always_comb begin
		prod_p = pcc_pkg::PROD_P_W'(cfg.prop_gain) * pcc_pkg::PROD_P_W'(in_beat.err);
		prod_i = pcc_pkg::PROD_I_W'(cfg.int_gain) * pcc_pkg::PROD_I_W'(in_beat.acc);

		sum  = pcc_pkg::SUM_W'(prod_p_s3) + pcc_pkg::SUM_W'(prod_i_s3);
		neg  = sum[pcc_pkg::SUM_W-1];
		mag  = neg ? unsigned'(-sum) : unsigned'(sum);
		quo  = mag[pcc_pkg::SUM_W-1:pcc_pkg::FRAC_W];
		dmag = (quo > QW'(cfg.bridge_period)) ? cfg.bridge_period : quo[15:0];
		pos  = !neg && (dmag != '0);
		period_less = cfg.bridge_period - dmag;
		drive_d = neg ? -signed'({1'b0, dmag}) : signed'({1'b0, dmag});
		if (done_s3) begin
			fwd_d = cfg.bridge_period;
			rev_d = cfg.bridge_period;
		end else begin
			fwd_d = pos ? period_less : cfg.bridge_period;
			rev_d = pos ? cfg.bridge_period : period_less;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s3 <= in_valid;
			end
			if (rdy_o) begin
				v_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			prod_p_s3 <= prod_p;
			prod_i_s3 <= prod_i;
			target_s3 <= in_beat.target;
			idx_s3    <= in_beat.idx;
			active_s3 <= in_beat.active;
			done_s3   <= in_beat.done;
		end
		if (adv_s3) begin
			compare_fwd    <= fwd_d;
			compare_rev    <= rev_d;
			drive          <= drive_d;
			target_current <= target_s3;
			step_index     <= idx_s3;
			active         <= active_s3;
			run_done       <= done_s3;
		end
	end

endmodule
`default_nettype wire

>>> rtl/pi_current_controller.sv
// Top level of the PI current controller with integrator clamp and H-bridge mapping.
// Pipeline: a beat passes the input register, sequencer stage, multiplier stage and output
// register in that order, one beat per cycle while m_axis_tready does not stall; each stage
// holds one beat and advances when the stage after it is empty or advancing.
// Reset: arst_n clears all valid flags and run state, loads the register reset values,
// and sets the stored target to target_a's reset value.
`timescale 1ns / 1ps
`default_nettype none
module pi_current_controller #(
	parameter int unsigned MAX_RUN_LENGTH = pcc_pkg::MAX_RUN_LENGTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [15:0]                  s_axis_tdata,  // current_sample
	input  wire logic                         s_axis_tuser,  // start_req
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// compare_fwd, compare_rev, drive, target_current, step_index, zero pad
	output logic [pcc_pkg::DATA_W-1:0]        m_axis_tdata,
	output logic                              m_axis_tuser,  // active
	output logic                              m_axis_tlast,  // run_done
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [2:0]                   cfg_index,
	input  wire logic [pcc_pkg::CFG_W-1:0]    cfg_data
);

	pcc_pkg::cfg_t                          cfg;
	pcc_pkg::step_beat_t                    beat;
	logic                                   beat_valid;
	logic                                   beat_ready;
	logic [15:0]                            compare_fwd;
	logic [15:0]                            compare_rev;
	logic signed [pcc_pkg::DRIVE_W-1:0]     drive;
	logic signed [15:0]                     target_current;
	logic [pcc_pkg::IDX_W-1:0]              step_index;

	pcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pcc_step #(
		.MAX_RUN_LENGTH (MAX_RUN_LENGTH)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_sample (signed'(s_axis_tdata)),
		.in_start  (s_axis_tuser),
		.out_valid (beat_valid),
		.out_ready (beat_ready),
		.out_beat  (beat)
	);

	pcc_drive u_drive (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (beat_valid),
		.in_ready       (beat_ready),
		.in_beat        (beat),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.compare_fwd    (compare_fwd),
		.compare_rev    (compare_rev),
		.drive          (drive),
		.target_current (target_current),
		.step_index     (step_index),
		.active         (m_axis_tuser),
		.run_done       (m_axis_tlast)
	);

	assign m_axis_tdata = {5'b00000, step_index, target_current, drive, compare_rev,
		compare_fwd};

endmodule
`default_nettype wire
